[hw/rtl/irts_pkg.sv]
package irts_pkg;

	localparam int CFG_COUNT = 8;
	localparam int CFG_IDX_W = 4;
	localparam int DUR_W = 16;
	localparam int POS_W = 9;
	localparam int OFF_W = 8;

	localparam logic [POS_W-1:0] PASS_LEN = 9'd140;
	localparam logic [POS_W-1:0] LAST_POS = 9'd278;

	// offsets inside one pass
	localparam logic [OFF_W-1:0] OFF_HDR_SPACE = 8'd1;
	localparam logic [OFF_W-1:0] OFF_LO_START = 8'd2;
	localparam logic [OFF_W-1:0] OFF_PAD_START = 8'd66;
	localparam logic [OFF_W-1:0] OFF_END_MARK0 = 8'd72;
	localparam logic [OFF_W-1:0] OFF_FRAME_GAP = 8'd73;
	localparam logic [OFF_W-1:0] OFF_HI_START = 8'd74;
	localparam logic [OFF_W-1:0] OFF_END_MARK1 = 8'd138;
	// bias that maps the upper half's offsets onto bit numbers 32 and up
	localparam logic [OFF_W-1:0] OFF_HI_BIAS = 8'd10;
	localparam logic [2:0] PAD_VALUE = 3'b010;

	localparam logic [7:0] B3_SET = 8'h20;
	localparam logic [7:0] B4_CLR = 8'h01;
	localparam logic [7:0] B5_CLR = 8'h40;
	localparam logic [7:0] B6_SET = 8'h20;
	localparam logic [7:0] FAN_MASK = 8'h30;
	localparam logic [3:0] MODE_HEAT = 4'hC;
	localparam logic [3:0] MODE_AUTO = 4'h8;
	localparam logic [7:0] HEAT_FAN_SUB = 8'h28;
	localparam logic [7:0] HEAT_AUTO_SUB = 8'h48;
	localparam logic [7:0] COOL_FAN_SUB = 8'h20;
	localparam logic [7:0] COOL_AUTO_SUB = 8'h40;
	localparam logic [7:0] AUTO_FAN_SUM = 8'hD0;
	localparam logic [7:0] AUTO_AUTO_SUM = 8'hB0;

	typedef enum logic [2:0] {
		CFG_HDR_MARK,
		CFG_HDR_SPACE,
		CFG_BIT_MARK,
		CFG_ONE_SPACE,
		CFG_ZERO_SPACE,
		CFG_END_MARK,
		CFG_FRAME_GAP,
		CFG_REPEAT_GAP
	} cfg_idx_t;

	typedef logic [CFG_COUNT-1:0][DUR_W-1:0] cfg_regs_t;

	localparam cfg_regs_t CFG_RESET = '{
		16'd40000, 16'd20000, 16'd620, 16'd620,
		16'd1660, 16'd620, 16'd4500, 16'd9000
	};

	typedef struct packed {
		logic act;
		logic [OFF_W-1:0] off;
		logic mark;
		logic last;
		logic [63:0] word;
	} entry_req_t;

	function automatic logic [63:0] second_pass_bytes(input logic [63:0] w);
		logic [7:0] b [8];
		logic fan;
		logic [63:0] r;
		for (int i = 0; i < 8; i++) b[i] = w[i*8 +: 8];
		fan = (b[0] & FAN_MASK) != 8'h00;
		b[3] = b[3] | B3_SET;
		b[4] = b[4] & ~B4_CLR;
		b[5] = b[5] & ~B5_CLR;
		if (fan) b[6] = b[6] | B6_SET;
		if (b[0][3:0] == MODE_HEAT)
			b[7] = w[63:56] - (fan ? HEAT_FAN_SUB : HEAT_AUTO_SUB);
		else if (b[0][3:0] == MODE_AUTO)
			b[7] = fan ? AUTO_FAN_SUM : AUTO_AUTO_SUM;
		else
			b[7] = w[63:56] - (fan ? COOL_FAN_SUB : COOL_AUTO_SUB);
		for (int i = 0; i < 8; i++) r[i*8 +: 8] = b[i];
		return r;
	endfunction

endpackage

[hw/rtl/ir_remote_timing_sequencer_top.sv]
// Infrared remote timing sequencer: turns an 8-byte frame into the 279
// mark/space durations of one raw transmission, one duration per item.
// Input stream s_*: s_tuser is the start flag. A start item latches s_tdata
// as the frame and yields entry 0; each following item with s_tuser low
// yields the next entry, up to entry 278, which carries m_tlast. A start
// while a transmission runs restarts it. A request while idle yields an
// item with m_tuser and m_tdata all zero.
// Output stream m_*: m_tdata is the duration in microseconds, m_tuser
// carries the valid flag and the mark flag.
// Configuration channel cfg_*: one 16-bit timing register per index 0..7,
// other indexes are ignored; write only while no item is in flight.
// Path from acceptance to the result on m_*: an input register holding
// the offset and the byte word of the pass, then the duration select into
// the output register. One item per cycle is taken; when m_tready is low
// the two registers fill and s_tready drops.
// Reset clears the position, the run flag and both stage valids and loads
// the default timings (9000/4500/620/1660/620/620/20000/40000 us).
module ir_remote_timing_sequencer_top
	import irts_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [63:0]            s_tdata,   // frame_bytes[63:0]
	input  logic [0:0]             s_tuser,   // [0] start_req
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [DUR_W-1:0]       m_tdata,   // duration_us[15:0]
	output logic [1:0]             m_tuser,   // [0] valid_res, [1] is_mark
	output logic                   m_tlast,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [DUR_W-1:0]       cfg_data
);

	cfg_regs_t cfg_q;
	logic [63:0] held_q;
	logic [POS_W-1:0] pos_q;
	logic active_q;

	logic s1_valid_q;
	entry_req_t req_s1;
	logic out_valid_q;
	logic [DUR_W-1:0] out_dur_q;
	logic [1:0] out_user_q;
	logic out_last_q;

	logic out_free;
	logic s1_adv;
	logic in_acc;
	logic start;
	logic run;
	logic [63:0] held_n;
	logic [POS_W-1:0] pos_c;
	logic second;
	logic [POS_W-1:0] off_full;
	logic [DUR_W-1:0] dur;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(CFG_COUNT))) begin
			cfg_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	assign out_free = !out_valid_q || m_tready;
	assign s1_adv = s1_valid_q && out_free;
	assign s_tready = !s1_valid_q || out_free;
	assign in_acc = s_tvalid && s_tready;

	assign start = s_tuser[0];
	assign run = start || active_q;
	assign held_n = start ? s_tdata : held_q;
	assign pos_c = start ? '0 : pos_q;
	assign second = pos_c >= PASS_LEN;
	assign off_full = second ? (pos_c - PASS_LEN) : pos_c;

	// sequence state moves at acceptance so the next item sees it at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			pos_q <= '0;
			active_q <= 1'b0;
		end else if (in_acc && run) begin
			held_q <= held_n;
			if (pos_c == LAST_POS) begin
				pos_q <= '0;
				active_q <= 1'b0;
			end else begin
				pos_q <= pos_c + 1'b1;
				active_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_s1.act <= run;
			req_s1.off <= off_full[OFF_W-1:0];
			req_s1.mark <= !pos_c[0];
			req_s1.last <= pos_c == LAST_POS;
			req_s1.word <= second ? second_pass_bytes(held_n) : held_n;
		end
	end

	irts_entry u_entry (
		.req (req_s1),
		.cfg (cfg_q),
		.dur (dur)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_dur_q <= req_s1.act ? dur : '0;
			out_user_q <= {req_s1.act && req_s1.mark, req_s1.act};
			out_last_q <= req_s1.act && req_s1.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_dur_q;
	assign m_tuser = out_user_q;
	assign m_tlast = out_last_q;

	// the final entry sits on an even position, so it is a valid mark
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[0] && m_tuser[1])
		else $error("last entry is not a valid mark");

	assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LAST_POS)
		else $error("position ran past the last entry");

	assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> pos_q == '0)
		else $error("idle with a nonzero position");

	// a full pipeline must stop taking items
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && m_tvalid && !m_tready |-> !s_tready)
		else $error("item taken while both stages are stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && s_tuser[0] |=> active_q || (pos_q == '0 && !active_q))
		else $error("start did not leave a consistent run state");

endmodule

[hw/rtl/irts_entry.sv]
module irts_entry
	import irts_pkg::*;
(
	input  entry_req_t             req,
	input  cfg_regs_t              cfg,
	output logic [DUR_W-1:0]       dur
);

	logic [OFF_W-1:0] lo_diff;
	logic [OFF_W-1:0] hi_diff;
	logic [OFF_W-1:0] pad_diff;
	logic [5:0] bit_idx;
	logic data_bit;
	logic pad_bit;
	logic [DUR_W-1:0] data_space;
	logic [DUR_W-1:0] pad_space;

	assign lo_diff = req.off - OFF_LO_START;
	assign hi_diff = req.off - OFF_HI_BIAS;
	assign pad_diff = req.off - OFF_PAD_START;

	// bytes 0-3 give bits 0..31, bytes 4-7 give 32..63
	assign bit_idx = (req.off < OFF_PAD_START) ? {1'b0, lo_diff[5:1]} : hi_diff[6:1];
	assign data_bit = req.word[bit_idx];
	assign pad_bit = PAD_VALUE[pad_diff[2:1]];
	assign data_space = data_bit ? cfg[CFG_ONE_SPACE] : cfg[CFG_ZERO_SPACE];
	assign pad_space = pad_bit ? cfg[CFG_ONE_SPACE] : cfg[CFG_ZERO_SPACE];

	always_comb begin
		priority if (req.off == '0) begin
			dur = cfg[CFG_HDR_MARK];
		end else if (req.off == OFF_HDR_SPACE) begin
			dur = cfg[CFG_HDR_SPACE];
		end else if (req.off < OFF_PAD_START) begin
			dur = req.off[0] ? data_space : cfg[CFG_BIT_MARK];
		end else if (req.off < OFF_END_MARK0) begin
			dur = req.off[0] ? pad_space : cfg[CFG_BIT_MARK];
		end else if (req.off == OFF_END_MARK0) begin
			dur = cfg[CFG_END_MARK];
		end else if (req.off == OFF_FRAME_GAP) begin
			dur = cfg[CFG_FRAME_GAP];
		end else if (req.off < OFF_END_MARK1) begin
			dur = req.off[0] ? data_space : cfg[CFG_BIT_MARK];
		end else if (req.off == OFF_END_MARK1) begin
			dur = cfg[CFG_END_MARK];
		end else begin
			dur = cfg[CFG_REPEAT_GAP];
		end
	end

endmodule
